### rtl/ring_buffer_fifo_assert.svh
// assertion macros for the ring buffer fifo checker
`ifndef RING_BUFFER_FIFO_ASSERT_SVH
`define RING_BUFFER_FIFO_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rbf_pkg.sv
// shared types, constants and helpers of the ring buffer fifo
`default_nettype none
package rbf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W = 64;
	localparam int BYTES_W = 4;
	localparam int STATED_W = 8;
	localparam int CAP_W = 5;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [BYTES_W-1:0] MAX_ITEM_BYTES = 4'd8;
	localparam logic [BYTES_W-1:0] ITEM_BYTES_RST = 4'd8;
	localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

	typedef enum logic [1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SIZE = 2'd1,
		ST_FULL = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ITEM_BYTES = 1'b0,
		REG_CAPACITY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [DATA_W-1:0] item_data;
		logic [STATED_W-1:0] stated_bytes;
	} rbf_req_t;

	typedef struct packed {
		status_t status;
		logic [DATA_W-1:0] read_data;
		logic [BYTES_W-1:0] read_bytes;
	} rbf_rsp_t;

	// one operation travelling down the cell chain
	typedef struct packed {
		logic valid;
		logic wr;
		logic rd;
		status_t status;
		logic [BYTES_W-1:0] rbytes;
		logic [DATA_W-1:0] data;
	} rbf_op_t;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (BYTES_W'(b) < n) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/ring_buffer_fifo.sv
// Ring buffer fifo of fixed-size items. Each request is an enqueue, a dequeue,
// a flush or the unused mode, which does nothing; status, head, tail and
// occupancy are settled when the request is taken, and the slot write or read
// then travels down a row of DEPTH cells, one cell per cycle while no response
// is stalled, each cell owning one slot. One request is taken every cycle
// unless a response is stalled; its response leaves the register of the last
// cell, and responses leave in request order. A stalled response holds the
// whole row. Configuration writes take effect on the next request.
`default_nettype none
module ring_buffer_fifo
	import rbf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic req_valid,
	output logic req_stall,
	input wire rbf_req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rbf_rsp_t rsp
);

	rbf_op_t op_chain [DEPTH+1];
	logic [IW-1:0] addr_chain [DEPTH+1];
	logic adv;
	logic fire;
	rbf_op_t last;

	assign adv = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;
	assign fire = req_valid && adv;

	rbf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.fire(fire),
		.req(req),
		.op(op_chain[0]),
		.addr(addr_chain[0])
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rbf_cell #(
			.DEPTH(DEPTH),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.op_in(op_chain[i]),
			.addr_in(addr_chain[i]),
			.op_out(op_chain[i+1]),
			.addr_out(addr_chain[i+1])
		);
	end

	assign last = op_chain[DEPTH];
	assign rsp_valid = last.valid;
	assign rsp.status = last.status;
	assign rsp.read_data = last.rd ? last.data : '0;
	assign rsp.read_bytes = last.rbytes;

endmodule
`default_nettype wire

### rtl/rbf_cell.sv
// one slot cell: holds a slot and applies the passing write or read to it
`default_nettype none
module rbf_cell
	import rbf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int INDEX = 0,
	localparam int IW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire rbf_op_t op_in,
	input wire logic [IW-1:0] addr_in,
	output rbf_op_t op_out,
	output logic [IW-1:0] addr_out
);

	logic [DATA_W-1:0] slot_q;
	rbf_op_t op_q;
	logic [IW-1:0] addr_q;
	logic hit;
	rbf_op_t op_nxt;

	assign hit = (addr_in == IW'(INDEX));

	always_comb begin
		op_nxt = op_in;
		if (op_in.rd && hit) begin
			op_nxt.data = slot_q & byte_mask(op_in.rbytes);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			addr_q <= '0;
		end else if (adv) begin
			op_q <= op_nxt;
			addr_q <= addr_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && op_in.valid && op_in.wr && hit) begin
			slot_q <= op_in.data;
		end
	end

	assign op_out = op_q;
	assign addr_out = addr_q;

endmodule
`default_nettype wire

### rtl/rbf_ctrl.sv
// entry control: config registers, head, tail and occupancy, status decision
`default_nettype none
module rbf_ctrl
	import rbf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic req_valid,
	input wire logic fire,
	input wire rbf_req_t req,
	output rbf_op_t op,
	output logic [IW-1:0] addr
);

	logic [BYTES_W-1:0] item_bytes_q;
	logic [CAP_W-1:0] capacity_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CAP_W-1:0] occ_q;
	logic [BYTES_W-1:0] size_eff;
	logic [CW-1:0] cap_eff;
	logic do_enq;
	logic do_deq;
	logic do_flush;

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
			input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(idx) + CW'(1);
		return (n >= cap) ? '0 : n[IW-1:0];
	endfunction

	always_comb begin
		if (item_bytes_q == '0) begin
			size_eff = BYTES_W'(1);
		end else if (item_bytes_q > MAX_ITEM_BYTES) begin
			size_eff = MAX_ITEM_BYTES;
		end else begin
			size_eff = item_bytes_q;
		end
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (CW'(capacity_q) > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(capacity_q);
		end
	end

	always_comb begin
		op = '0;
		op.valid = req_valid;
		op.status = ST_OK;
		addr = '0;
		do_enq = 1'b0;
		do_deq = 1'b0;
		do_flush = 1'b0;
		unique case (mode_t'(req.mode))
			MODE_ENQ: begin
				if (req.stated_bytes != STATED_W'(size_eff)) begin
					op.status = ST_SIZE;
				end else if (CW'(occ_q) >= cap_eff) begin
					op.status = ST_FULL;
				end else begin
					do_enq = 1'b1;
					op.wr = 1'b1;
					op.data = req.item_data & byte_mask(size_eff);
					addr = tail_q;
				end
			end
			MODE_DEQ: begin
				if (occ_q == '0) begin
					op.status = ST_EMPTY;
				end else begin
					do_deq = 1'b1;
					op.rd = 1'b1;
					op.rbytes = size_eff;
					addr = head_q;
				end
			end
			MODE_FLUSH: begin
				do_flush = 1'b1;
			end
			default: begin
				op.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bytes_q <= ITEM_BYTES_RST;
			capacity_q <= CAPACITY_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ITEM_BYTES: item_bytes_q <= cfg_data[BYTES_W-1:0];
				REG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
		end else if (fire) begin
			priority if (do_flush) begin
				head_q <= '0;
				tail_q <= '0;
				occ_q <= '0;
			end else if (do_enq) begin
				tail_q <= advance(tail_q, cap_eff);
				occ_q <= occ_q + CAP_W'(1);
			end else if (do_deq) begin
				head_q <= advance(head_q, cap_eff);
				occ_q <= occ_q - CAP_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/rbf_checker.sv
// port-level checks of the ring buffer fifo, bound to the top level
`default_nettype none
`include "ring_buffer_fifo_assert.svh"
module rbf_checker
	import rbf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rbf_rsp_t rsp
);

	`RBF_ASSERT_NOW(a_fail_no_data, rsp_valid && rsp.status != ST_OK, rsp.read_data == '0 && rsp.read_bytes == '0, "failed operation carries data")
	`RBF_ASSERT_NOW(a_stall_follows, rsp_valid && rsp_stall, req_stall, "request taken while response is held")
	`RBF_ASSERT_NOW(a_no_idle_stall, !rsp_valid, !req_stall, "request stalled with no response pending")
	`RBF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind ring_buffer_fifo rbf_checker u_rbf_checker (.*);
`default_nettype wire

### test/testbench.sv
// self-checking testbench for the ring buffer fifo: directed and random operations
`timescale 1ns / 1ps
module testbench;
	import rbf_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 40;
	localparam int SETTLE_CYCLES = 2 * DEPTH_DEF + 8;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ITEM_BYTES;
	logic [CFG_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	rbf_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rbf_rsp_t rsp;

	ring_buffer_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// shadow copy of the queue
	logic [DATA_W-1:0] shadow_slots [DEPTH_DEF];
	bit slot_written [DEPTH_DEF];
	logic [3:0] shadow_head = '0;
	logic [3:0] shadow_tail = '0;
	logic [4:0] shadow_count = '0;
	logic [BYTES_W-1:0] shadow_item_bytes = ITEM_BYTES_RST;
	logic [CAP_W-1:0] shadow_capacity = CAPACITY_RST;

	rbf_rsp_t pending_rsp [$];
	int failures = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int phase_no = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [BYTES_W-1:0] acted_size();
		if (shadow_item_bytes == 0) return 4'd1;
		if (shadow_item_bytes > MAX_ITEM_BYTES) return MAX_ITEM_BYTES;
		return shadow_item_bytes;
	endfunction

	function automatic logic [4:0] acted_cap();
		if (shadow_capacity == 0) return 5'd1;
		if (shadow_capacity > DEPTH_DEF) return 5'(DEPTH_DEF);
		return shadow_capacity;
	endfunction

	function automatic logic [DATA_W-1:0] keep_low_bytes(input logic [DATA_W-1:0] v,
			input logic [BYTES_W-1:0] n);
		if (n >= 8) return v;
		return v & ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	function automatic logic [3:0] next_index(input logic [3:0] idx, input logic [4:0] cap);
		logic [4:0] n;
		n = {1'b0, idx} + 5'd1;
		return (n >= cap) ? 4'd0 : n[3:0];
	endfunction

	task automatic predict_response(input rbf_req_t op);
		rbf_rsp_t r;
		logic [BYTES_W-1:0] sz;
		logic [4:0] cap;
		sz = acted_size();
		cap = acted_cap();
		r.status = ST_OK;
		r.read_data = '0;
		r.read_bytes = '0;
		case (op.mode)
			MODE_ENQ: begin
				if (op.stated_bytes != {4'd0, sz}) begin
					r.status = ST_SIZE;
				end else if (shadow_count >= cap) begin
					r.status = ST_FULL;
				end else begin
					shadow_slots[shadow_tail] = keep_low_bytes(op.item_data, sz);
					slot_written[shadow_tail] = 1'b1;
					shadow_tail = next_index(shadow_tail, cap);
					shadow_count = shadow_count + 5'd1;
				end
			end
			MODE_DEQ: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_data = keep_low_bytes(shadow_slots[shadow_head], sz);
					r.read_bytes = sz;
					shadow_head = next_index(shadow_head, cap);
					shadow_count = shadow_count - 5'd1;
				end
			end
			MODE_FLUSH: begin
				shadow_head = '0;
				shadow_tail = '0;
				shadow_count = '0;
			end
			default: ;
		endcase
		pending_rsp.push_back(r);
	endtask

	task automatic push_request(input logic [1:0] mode, input logic [DATA_W-1:0] data,
			input logic [STATED_W-1:0] stated);
		rbf_req_t op;
		op.mode = mode;
		op.item_data = data;
		op.stated_bytes = stated;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= op;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_response(op);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic configure(input logic [3:0] ib, input logic [4:0] cap);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= REG_ITEM_BYTES;
		cfg_data <= {1'b0, ib};
		@(posedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_write <= 1'b0;
		shadow_item_bytes = ib;
		shadow_capacity = cap;
	endtask

	always @(posedge clk) begin : check_rsp
		rbf_rsp_t want;
		if (arst_n) begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("response transfer with nothing outstanding");
					failures++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						failures++;
					end
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data,
							rsp.read_data);
						failures++;
					end
					if (rsp.read_bytes !== want.read_bytes) begin
						$error("read_bytes: expected %0d, got %0d", want.read_bytes,
							rsp.read_bytes);
						failures++;
					end
				end
			end
		end
	end

	task automatic test_basic_ops();
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_ENQ, '1, 8'd0);
		push_request(MODE_ENQ, '1, 8'd255);
		push_request(MODE_ENQ, '1, 8'd8);
		push_request(MODE_ENQ, '0, 8'd8);
		push_request(MODE_UNUSED, '1, 8'd255);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_FLUSH, '1, 8'd8);
	endtask

	// out of range zeros act as one byte and one slot
	task automatic test_full_and_clamp();
		configure(4'd0, 5'd0);
		push_request(MODE_ENQ, '1, 8'd1);
		push_request(MODE_ENQ, '1, 8'd1);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_ENQ, 64'h1234, 8'd1);
		push_request(MODE_FLUSH, '0, 8'd0);
	endtask

	task automatic test_stored_width();
		configure(4'd3, 5'd31);
		push_request(MODE_ENQ, '1, 8'd3);
		configure(4'd15, 5'd31);
		push_request(MODE_ENQ, '1, 8'd8);
		push_request(MODE_DEQ, '0, 8'd0);
		configure(4'd2, 5'd31);
		push_request(MODE_DEQ, '0, 8'd0);
	endtask

	// capacity lowered under occupancy, tail left past the wrap point
	task automatic test_capacity_shrink();
		configure(4'd8, 5'd16);
		push_request(MODE_ENQ, {$urandom, $urandom}, 8'd8);
		push_request(MODE_ENQ, {$urandom, $urandom}, 8'd8);
		push_request(MODE_ENQ, {$urandom, $urandom}, 8'd8);
		configure(4'd8, 5'd2);
		push_request(MODE_ENQ, '1, 8'd8);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_DEQ, '0, 8'd0);
		push_request(MODE_DEQ, '0, 8'd0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int phases);
		int enq_pct;
		int r;
		logic [1:0] mode;
		logic [DATA_W-1:0] data;
		logic [STATED_W-1:0] stated;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int p = 0; p < phases; p++) begin
			case (phase_no % 4)
				0: configure(4'd1, 5'd1);
				1: configure(4'd8, 5'd16);
				2: configure(4'($urandom_range(15)), 5'($urandom_range(31)));
				default: configure(4'($urandom_range(8, 1)), 5'($urandom_range(16, 1)));
			endcase
			phase_no++;
			enq_pct = $urandom_range(70, 30);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) wait_drained();
				r = $urandom_range(99);
				if (r < enq_pct) mode = MODE_ENQ;
				else if (r < 94) mode = MODE_DEQ;
				else if (r < 97) mode = MODE_FLUSH;
				else mode = MODE_UNUSED;
				// never read a slot that was never written
				if (mode == MODE_DEQ && shadow_count != 0 && !slot_written[shadow_head])
					mode = MODE_FLUSH;
				data = ($urandom_range(15) == 0) ? '1 : {$urandom, $urandom};
				stated = ($urandom_range(99) < 85) ? {4'd0, acted_size()} :
					8'($urandom_range(255));
				push_request(mode, data, stated);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH_DEF; i++) slot_written[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_and_clamp();
		test_stored_width();
		test_capacity_shrink();
		test_random_traffic(35, 80, 4);
		test_random_traffic(80, 35, 4);
		test_random_traffic(0, 0, 4);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
